FILE: rtl/stl_pkg.sv
// Shared types and codes of the source text lexer.
package stl_pkg;

    localparam int POS_WIDTH  = 24;
    localparam int LINE_WIDTH = 20;
    localparam int COL_WIDTH  = 16;
    localparam int LEN_WIDTH  = 16;

    localparam logic [4:0] K_PLUS   = 5'd0;
    localparam logic [4:0] K_MINUS  = 5'd1;
    localparam logic [4:0] K_SLASH  = 5'd2;
    localparam logic [4:0] K_STAR   = 5'd3;
    localparam logic [4:0] K_LPAREN = 5'd4;
    localparam logic [4:0] K_RPAREN = 5'd5;
    localparam logic [4:0] K_LBRACE = 5'd6;
    localparam logic [4:0] K_RBRACE = 5'd7;
    localparam logic [4:0] K_SEMI   = 5'd8;
    localparam logic [4:0] K_BANG   = 5'd9;
    localparam logic [4:0] K_ASSIGN = 5'd11;
    localparam logic [4:0] K_LT     = 5'd13;
    localparam logic [4:0] K_GT     = 5'd15;
    localparam logic [4:0] K_DOT    = 5'd17;
    localparam logic [4:0] K_COMMA  = 5'd18;
    localparam logic [4:0] K_CARET  = 5'd19;
    localparam logic [4:0] K_NUMBER = 5'd20;
    localparam logic [4:0] K_IDENT  = 5'd21;
    localparam logic [4:0] K_STRING = 5'd22;
    localparam logic [4:0] K_SBYTE  = 5'd23;
    localparam logic [4:0] K_ERROR  = 5'd24;

    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_MALFORMED = 3'd1;
    localparam logic [2:0] E_UNTERM    = 3'd2;
    localparam logic [2:0] E_BAD_ESC   = 3'd3;
    localparam logic [2:0] E_OPEN_CMT  = 3'd4;
    localparam logic [2:0] E_ILLEGAL   = 3'd5;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } t_lex_in;

    typedef struct packed {
        logic [4:0]            kind;
        logic [POS_WIDTH-1:0]  start_offset;
        logic [LINE_WIDTH-1:0] start_line;
        logic [COL_WIDTH-1:0]  start_column;
        logic [LEN_WIDTH-1:0]  token_length;
        logic [7:0]            payload_byte;
        logic [2:0]            error_code;
        logic                  last_of_run;
    } t_lex_out;

endpackage

FILE: rtl/source_text_lexer_unit.sv
// Streaming lexer for C-style source text, one byte per beat.
//
//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+---------------------------
//  in      | sink      | i_in_valid / o_in_stall   | one source byte + last flag
//  out     | source    | o_out_valid / i_out_stall | one token or string byte
//
//  A byte is held in the input register and is lexed on its way into
//  a two-entry result register; a new byte enters every cycle while the
//  output is not stalled and each byte yields at most one result.
//  A byte that yields two results holds back the next byte until the second
//  leaves, the result register draining one beat a cycle while not stalled.
//  Reset is synchronous, active low, and clears mode, counters and valids.
//  A stall on the output backs up into o_in_stall once the input register
//  has a byte that cannot move on.
module source_text_lexer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stl_pkg::t_lex_in    i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output stl_pkg::t_lex_out   o_out_data
);

    localparam logic [7:0] C_BS    = 8'h08;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_NL    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_SP    = 8'h20;
    localparam logic [7:0] C_BANG  = 8'h21;
    localparam logic [7:0] C_DQ    = 8'h22;
    localparam logic [7:0] C_SQ    = 8'h27;
    localparam logic [7:0] C_LPAR  = 8'h28;
    localparam logic [7:0] C_RPAR  = 8'h29;
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_COMMA = 8'h2C;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_LT    = 8'h3C;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_UA    = 8'h41;
    localparam logic [7:0] C_UZ    = 8'h5A;
    localparam logic [7:0] C_BSL   = 8'h5C;
    localparam logic [7:0] C_CARET = 8'h5E;
    localparam logic [7:0] C_USCR  = 8'h5F;
    localparam logic [7:0] C_LA    = 8'h61;
    localparam logic [7:0] C_LB    = 8'h62;
    localparam logic [7:0] C_LN    = 8'h6E;
    localparam logic [7:0] C_LR    = 8'h72;
    localparam logic [7:0] C_LT_T  = 8'h74;
    localparam logic [7:0] C_LZ    = 8'h7A;
    localparam logic [7:0] C_LBR   = 8'h7B;
    localparam logic [7:0] C_RBR   = 8'h7D;

    localparam int PW = stl_pkg::POS_WIDTH;
    localparam int LW = stl_pkg::LINE_WIDTH;
    localparam int CW = stl_pkg::COL_WIDTH;
    localparam int NW = stl_pkg::LEN_WIDTH;

    typedef enum logic [3:0] {
        M_IDLE, M_OP, M_NUM, M_IDENT, M_STR, M_ESC, M_LINE, M_BLOCK, M_STAR
    } t_mode;

    function automatic logic [4:0] single_kind(input logic [7:0] ch);
        logic [4:0] k;
        case (ch)
            C_BANG:  k = stl_pkg::K_BANG;
            C_EQ:    k = stl_pkg::K_ASSIGN;
            C_LT:    k = stl_pkg::K_LT;
            C_GT:    k = stl_pkg::K_GT;
            default: k = stl_pkg::K_SLASH;
        endcase
        return k;
    endfunction

    function automatic stl_pkg::t_lex_out mk(
        input logic [4:0]    k,
        input logic [PW-1:0] off,
        input logic [LW-1:0] ln,
        input logic [CW-1:0] col,
        input logic [NW-1:0] len,
        input logic [7:0]    pay,
        input logic [2:0]    err
    );
        stl_pkg::t_lex_out r;
        r.kind         = k;
        r.start_offset = off;
        r.start_line   = ln;
        r.start_column = col;
        r.token_length = len;
        r.payload_byte = pay;
        r.error_code   = err;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    logic              r_in_vld;
    stl_pkg::t_lex_in  r_in;
    stl_pkg::t_lex_out r_ob [2];
    logic [1:0]        r_ob_cnt;

    t_mode         r_mode,    n_mode;
    logic [7:0]    r_pend,    n_pend;
    logic [7:0]    r_quote,   n_quote;
    logic [1:0]    r_dots,    n_dots;
    logic [PW-1:0] r_pos,     n_pos;
    logic [LW-1:0] r_line,    n_line;
    logic [CW-1:0] r_col,     n_col;
    logic [PW-1:0] r_tok_pos, n_tok_pos;
    logic [LW-1:0] r_tok_ln,  n_tok_ln;
    logic [CW-1:0] r_tok_col, n_tok_col;
    logic [NW-1:0] r_len,     n_len;

    logic              in_take, out_take, move;
    logic [7:0]        c;
    logic              is_nl;
    logic [PW-1:0]     pos;
    logic [CW-1:0]     col;
    logic              do_idle;
    logic [7:0]        esc_val;
    logic [2:0]        esc_err;
    stl_pkg::t_lex_out p [3];
    logic [2:0]        p_vld;
    stl_pkg::t_lex_out res0, res1;
    logic [1:0]        res_cnt;

    assign o_out_valid = (r_ob_cnt != 2'd0);
    assign o_out_data  = r_ob[0];
    assign out_take    = o_out_valid && !i_out_stall;
    assign move        = r_in_vld && ((r_ob_cnt == 2'd0) || ((r_ob_cnt == 2'd1) && out_take));
    assign o_in_stall  = r_in_vld && !move;
    assign in_take     = i_in_valid && !o_in_stall;

    always_comb begin
        n_mode    = r_mode;
        n_pend    = r_pend;
        n_quote   = r_quote;
        n_dots    = r_dots;
        n_tok_pos = r_tok_pos;
        n_tok_ln  = r_tok_ln;
        n_tok_col = r_tok_col;
        n_len     = r_len;
        do_idle   = 1'b0;
        esc_val   = 8'h00;
        esc_err   = stl_pkg::E_NONE;
        p_vld     = 3'b000;
        for (int i = 0; i < 3; i++) begin
            p[i] = '0;
        end

        c     = r_in.char_in;
        is_nl = (c == C_NL);
        pos   = r_pos;
        if (is_nl) begin
            n_line = r_line + LW'(1);
            col    = '0;
        end else begin
            n_line = r_line;
            col    = r_col;
        end
        n_col = col + CW'(1);
        n_pos = pos + PW'(1);

        case (r_mode)
            M_OP: begin
                if (r_pend == C_SLASH && c == C_SLASH) begin
                    n_mode = M_LINE;
                end else if (r_pend == C_SLASH && c == C_STAR) begin
                    if (n_len != '1) n_len = n_len + NW'(1);
                    n_mode = M_BLOCK;
                end else if (r_pend != C_SLASH && c == C_EQ) begin
                    if (n_len != '1) n_len = n_len + NW'(1);
                    p[0] = mk(single_kind(r_pend) + 5'd1, n_tok_pos, n_tok_ln, n_tok_col,
                              n_len, 8'h00, stl_pkg::E_NONE);
                    p_vld[0] = 1'b1;
                    n_mode = M_IDLE;
                end else begin
                    p[0] = mk(single_kind(r_pend), n_tok_pos, n_tok_ln, n_tok_col,
                              n_len, 8'h00, stl_pkg::E_NONE);
                    p_vld[0] = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_NUM: begin
                if ((c >= C_ZERO && c <= C_NINE) || c == C_DOT) begin
                    if (c == C_DOT && r_dots < 2'd2) n_dots = r_dots + 2'd1;
                    if (n_len != '1) n_len = n_len + NW'(1);
                end else begin
                    p[0] = mk(stl_pkg::K_NUMBER, n_tok_pos, n_tok_ln, n_tok_col, n_len, 8'h00,
                              (r_dots > 2'd1) ? stl_pkg::E_MALFORMED : stl_pkg::E_NONE);
                    p_vld[0] = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_IDENT: begin
                if (c inside {[C_LA:C_LZ], [C_UA:C_UZ], [C_ZERO:C_NINE], C_USCR}) begin
                    if (n_len != '1) n_len = n_len + NW'(1);
                end else begin
                    p[0] = mk(stl_pkg::K_IDENT, n_tok_pos, n_tok_ln, n_tok_col, n_len, 8'h00,
                              stl_pkg::E_NONE);
                    p_vld[0] = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_STR: begin
                if (is_nl) begin
                    p[0] = mk(stl_pkg::K_STRING, n_tok_pos, n_tok_ln, n_tok_col, n_len, 8'h00,
                              stl_pkg::E_UNTERM);
                    p_vld[0] = 1'b1;
                    n_mode = M_IDLE;
                end else begin
                    if (n_len != '1) n_len = n_len + NW'(1);
                    if (c == r_quote) begin
                        p[0] = mk(stl_pkg::K_STRING, n_tok_pos, n_tok_ln, n_tok_col, n_len,
                                  8'h00, stl_pkg::E_NONE);
                        p_vld[0] = 1'b1;
                        n_mode = M_IDLE;
                    end else if (c == C_BSL) begin
                        n_mode = M_ESC;
                    end else begin
                        p[0] = mk(stl_pkg::K_SBYTE, pos, n_line, col, NW'(1), c,
                                  stl_pkg::E_NONE);
                        p_vld[0] = 1'b1;
                    end
                end
            end
            M_ESC: begin
                if (is_nl) begin
                    p[0] = mk(stl_pkg::K_STRING, n_tok_pos, n_tok_ln, n_tok_col, n_len, 8'h00,
                              stl_pkg::E_UNTERM);
                    p_vld[0] = 1'b1;
                    n_mode = M_IDLE;
                end else begin
                    if (n_len != '1) n_len = n_len + NW'(1);
                    case (c)
                        C_LN:             esc_val = C_NL;
                        C_LT_T:           esc_val = C_TAB;
                        C_LR:             esc_val = C_CR;
                        C_LB:             esc_val = C_BS;
                        C_SQ, C_DQ, C_BSL: esc_val = c;
                        C_ZERO:           esc_val = 8'h00;
                        default: begin
                            esc_val = c;
                            esc_err = stl_pkg::E_BAD_ESC;
                        end
                    endcase
                    p[0] = mk(stl_pkg::K_SBYTE, pos - PW'(1), n_line, col - CW'(1), NW'(2),
                              esc_val, esc_err);
                    p_vld[0] = 1'b1;
                    n_mode = M_STR;
                end
            end
            M_LINE: begin
                if (is_nl) n_mode = M_IDLE;
            end
            M_BLOCK: begin
                if (n_len != '1) n_len = n_len + NW'(1);
                if (c == C_STAR) n_mode = M_STAR;
            end
            M_STAR: begin
                if (n_len != '1) n_len = n_len + NW'(1);
                if (c == C_SLASH) n_mode = M_IDLE;
                else if (c != C_STAR) n_mode = M_BLOCK;
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        if (do_idle) begin
            n_mode = M_IDLE;
            if (!(c inside {C_SP, C_TAB, C_NL, C_CR, C_BS})) begin
                n_tok_pos = pos;
                n_tok_ln  = n_line;
                n_tok_col = col;
                n_len     = NW'(1);
                p_vld[1]  = 1'b1;
                p[1] = mk(stl_pkg::K_ERROR, pos, n_line, col, NW'(1), 8'h00,
                          stl_pkg::E_ILLEGAL);
                case (c)
                    C_PLUS:  p[1].kind = stl_pkg::K_PLUS;
                    C_MINUS: p[1].kind = stl_pkg::K_MINUS;
                    C_STAR:  p[1].kind = stl_pkg::K_STAR;
                    C_LPAR:  p[1].kind = stl_pkg::K_LPAREN;
                    C_RPAR:  p[1].kind = stl_pkg::K_RPAREN;
                    C_LBR:   p[1].kind = stl_pkg::K_LBRACE;
                    C_RBR:   p[1].kind = stl_pkg::K_RBRACE;
                    C_SEMI:  p[1].kind = stl_pkg::K_SEMI;
                    C_DOT:   p[1].kind = stl_pkg::K_DOT;
                    C_COMMA: p[1].kind = stl_pkg::K_COMMA;
                    C_CARET: p[1].kind = stl_pkg::K_CARET;
                    C_BANG, C_EQ, C_LT, C_GT, C_SLASH: begin
                        p_vld[1] = 1'b0;
                        n_pend   = c;
                        n_mode   = M_OP;
                    end
                    C_DQ, C_SQ: begin
                        p_vld[1] = 1'b0;
                        n_quote  = c;
                        n_mode   = M_STR;
                    end
                    default: begin
                        if (c >= C_ZERO && c <= C_NINE) begin
                            p_vld[1] = 1'b0;
                            n_dots   = 2'd0;
                            n_mode   = M_NUM;
                        end else if (c inside {[C_LA:C_LZ], [C_UA:C_UZ], C_USCR}) begin
                            p_vld[1] = 1'b0;
                            n_mode   = M_IDENT;
                        end
                    end
                endcase
                if (p_vld[1]) p[1].error_code = (p[1].kind == stl_pkg::K_ERROR) ?
                                                stl_pkg::E_ILLEGAL : stl_pkg::E_NONE;
            end
        end

        if (r_in.end_of_text) begin
            p[2] = mk(stl_pkg::K_STRING, n_tok_pos, n_tok_ln, n_tok_col, n_len, 8'h00,
                      stl_pkg::E_UNTERM);
            case (n_mode)
                M_OP: begin
                    p[2].kind       = single_kind(n_pend);
                    p[2].error_code = stl_pkg::E_NONE;
                    p_vld[2] = 1'b1;
                end
                M_NUM: begin
                    p[2].kind       = stl_pkg::K_NUMBER;
                    p[2].error_code = (n_dots > 2'd1) ? stl_pkg::E_MALFORMED : stl_pkg::E_NONE;
                    p_vld[2] = 1'b1;
                end
                M_IDENT: begin
                    p[2].kind       = stl_pkg::K_IDENT;
                    p[2].error_code = stl_pkg::E_NONE;
                    p_vld[2] = 1'b1;
                end
                M_STR, M_ESC: begin
                    p_vld[2] = 1'b1;
                end
                M_BLOCK, M_STAR: begin
                    p[2].kind       = stl_pkg::K_ERROR;
                    p[2].error_code = stl_pkg::E_OPEN_CMT;
                    p_vld[2] = 1'b1;
                end
                default: begin
                    p_vld[2] = 1'b0;
                end
            endcase
            n_mode = M_IDLE;
            n_pos  = '0;
            n_line = '0;
            n_col  = '0;
        end

        if (p_vld[0]) begin
            res0 = p[0];
            res1 = p_vld[1] ? p[1] : p[2];
        end else if (p_vld[1]) begin
            res0 = p[1];
            res1 = p[2];
        end else begin
            res0 = p[2];
            res1 = p[2];
        end
        res_cnt = {1'b0, p_vld[0]} + {1'b0, p_vld[1]} + {1'b0, p_vld[2]};
        if (res_cnt == 2'd1) res0.last_of_run = 1'b1;
        if (res_cnt == 2'd2) res1.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_in <= i_in_data;
        if (move) begin
            r_ob[0] <= res0;
            r_ob[1] <= res1;
        end else if (out_take) begin
            r_ob[0] <= r_ob[1];
        end
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_ob_cnt  <= 2'd0;
            r_mode    <= M_IDLE;
            r_pend    <= '0;
            r_quote   <= '0;
            r_dots    <= '0;
            r_pos     <= '0;
            r_line    <= '0;
            r_col     <= '0;
            r_tok_pos <= '0;
            r_tok_ln  <= '0;
            r_tok_col <= '0;
            r_len     <= '0;
        end else begin
            if (in_take) r_in_vld <= 1'b1;
            else if (move) r_in_vld <= 1'b0;
            if (move) begin
                r_ob_cnt  <= res_cnt;
                r_mode    <= n_mode;
                r_pend    <= n_pend;
                r_quote   <= n_quote;
                r_dots    <= n_dots;
                r_pos     <= n_pos;
                r_line    <= n_line;
                r_col     <= n_col;
                r_tok_pos <= n_tok_pos;
                r_tok_ln  <= n_tok_ln;
                r_tok_col <= n_tok_col;
                r_len     <= n_len;
            end else if (out_take) begin
                r_ob_cnt <= r_ob_cnt - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/stl_checker.sv
// Port-level checks of the source text lexer and their binding.
module stl_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input stl_pkg::t_lex_in  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input stl_pkg::t_lex_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat dropped or changed");

    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled while no result waits");

    a_error_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == stl_pkg::K_ERROR |->
            o_out_data.error_code == stl_pkg::E_OPEN_CMT ||
            o_out_data.error_code == stl_pkg::E_ILLEGAL)
        else $error("error-only beat with wrong code");

    a_sbyte_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == stl_pkg::K_SBYTE |->
            o_out_data.token_length == stl_pkg::LEN_WIDTH'(1) ||
            o_out_data.token_length == stl_pkg::LEN_WIDTH'(2))
        else $error("string byte with bad length");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != stl_pkg::K_SBYTE |-> o_out_data.payload_byte == 8'h00)
        else $error("payload set on a token beat");

endmodule

bind source_text_lexer_unit stl_checker u_stl_checker (.*);
